### design/msx_pkg.sv
// Shared definitions for the MIPS subset execute unit: sizes, command and
// status codes, and the result record passed from the execute logic.
// Depends on nothing; every other design file imports it.
`default_nettype none

package msx_pkg;

  // Data memory size in words and its address width.
  localparam int unsigned MEM_WORDS = 1024;
  localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);

  // Stream payload widths, rounded up to whole bytes.
  localparam int unsigned S_TDATA_W = 88;
  localparam int unsigned M_TDATA_W = 120;

  // Instruction codes.
  typedef enum logic [3:0] {
    CMD_ADD  = 4'd0,
    CMD_SUB  = 4'd1,
    CMD_AND  = 4'd2,
    CMD_OR   = 4'd3,
    CMD_SLT  = 4'd4,
    CMD_JR   = 4'd5,
    CMD_ADDI = 4'd6,
    CMD_LW   = 4'd7,
    CMD_SW   = 4'd8,
    CMD_BEQ  = 4'd9,
    CMD_J    = 4'd10,
    CMD_JAL  = 4'd11
  } cmd_e;

  // Completion status of one instruction.
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_ADDR = 2'd2
  } status_e;

  // Outcome of executing one instruction, before the load data is known.
  typedef struct packed {
    status_e     status;
    logic [31:0] npc;
    logic        reg_wr;
    logic [4:0]  widx;
    logic [31:0] wval;
    logic        ld;
    logic        mem_wr;
    logic        mem_acc;
    logic [32:0] maddr;
    logic [31:0] mval;
  } exec_t;

endpackage

`default_nettype wire

### design/msx_exec.sv
// Execute logic of the MIPS subset unit: ALU, overflow and address checks,
// next program counter. Purely combinational; imports msx_pkg.
// Load data is merged later by the top level.
`default_nettype none

module msx_exec (
  input  msx_pkg::cmd_e       cmd_i,
  input  logic signed [31:0]  a_i,
  input  logic signed [31:0]  b_i,
  input  logic [4:0]          rt_i,
  input  logic [4:0]          rd_i,
  input  logic signed [31:0]  imm_i,
  input  logic signed [31:0]  jt_i,
  input  logic [31:0]         pc_i,
  output msx_pkg::exec_t      res_o
);
  import msx_pkg::*;

  localparam logic signed [34:0] PcLim  = 35'(4 * MEM_WORDS);
  localparam logic signed [32:0] MemLim = 33'(MEM_WORDS);

  logic signed [32:0] add_s;
  logic signed [32:0] sub_s;
  logic signed [32:0] addi_s;
  logic signed [34:0] a_x;
  logic signed [34:0] br_t;
  logic signed [34:0] jt_t;
  logic [31:0]        seq;
  logic               mem_bad;
  exec_t              r;
  status_e            st;

  // Wide sums, so that overflow and out-of-range addresses are visible.
  assign add_s  = {a_i[31], a_i} + {b_i[31], b_i};
  assign sub_s  = {a_i[31], a_i} - {b_i[31], b_i};
  assign addi_s = {a_i[31], a_i} + {imm_i[31], imm_i};
  assign a_x    = {{3{a_i[31]}}, a_i};
  assign br_t   = {3'b000, pc_i} + {imm_i[31], imm_i, 2'b00};
  assign jt_t   = {jt_i[31], jt_i, 2'b00};
  assign seq    = pc_i + 32'd4;
  assign mem_bad = addi_s[32] || (addi_s >= MemLim);

  // Decode and evaluate the instruction, squash everything on an error, skip writes to register zero.
  always_comb begin
    r        = '0;
    r.status = ST_OK;
    r.npc    = seq;
    case (cmd_i)
      CMD_ADD: begin
        r.wval   = add_s[31:0];
        r.widx   = rd_i;
        r.reg_wr = 1'b1;
        if (add_s[32] != add_s[31]) r.status = ST_OVF;
      end
      CMD_SUB: begin
        r.wval   = sub_s[31:0];
        r.widx   = rd_i;
        r.reg_wr = 1'b1;
        if (sub_s[32] != sub_s[31]) r.status = ST_OVF;
      end
      CMD_AND: begin
        r.wval   = a_i & b_i;
        r.widx   = rd_i;
        r.reg_wr = 1'b1;
      end
      CMD_OR: begin
        r.wval   = a_i | b_i;
        r.widx   = rd_i;
        r.reg_wr = 1'b1;
      end
      CMD_SLT: begin
        r.wval   = {31'd0, (a_i < b_i)};
        r.widx   = rd_i;
        r.reg_wr = 1'b1;
      end
      CMD_JR: begin
        if (a_x < 0 || a_x >= PcLim) r.status = ST_ADDR;
        else r.npc = a_i;
      end
      CMD_ADDI: begin
        r.wval   = addi_s[31:0];
        r.widx   = rt_i;
        r.reg_wr = 1'b1;
        if (addi_s[32] != addi_s[31]) r.status = ST_OVF;
      end
      CMD_LW: begin
        if (mem_bad) begin
          r.status = ST_ADDR;
        end else begin
          r.mem_acc = 1'b1;
          r.ld      = 1'b1;
          r.maddr   = addi_s;
          r.widx    = rt_i;
          r.reg_wr  = 1'b1;
        end
      end
      CMD_SW: begin
        if (mem_bad) begin
          r.status = ST_ADDR;
        end else begin
          r.mem_acc = 1'b1;
          r.mem_wr  = 1'b1;
          r.maddr   = addi_s;
          r.mval    = b_i;
        end
      end
      CMD_BEQ: begin
        if (a_i == b_i) begin
          if (br_t < 0 || br_t >= PcLim) r.status = ST_ADDR;
          else r.npc = br_t[31:0];
        end
      end
      CMD_J, CMD_JAL: begin
        if (jt_t < 0 || jt_t >= PcLim) begin
          r.status = ST_ADDR;
        end else begin
          r.npc = jt_t[31:0];
          if (cmd_i == CMD_JAL) begin
            r.wval   = seq;
            r.widx   = 5'd31;
            r.reg_wr = 1'b1;
          end
        end
      end
      default: ;
    endcase

    st = r.status;
    if (st != ST_OK) begin
      // Failed instruction: no state change, pc stays put.
      r        = '0;
      r.status = st;
      r.npc    = pc_i;
    end else if (r.widx == 5'd0) begin
      // Register zero is never written.
      r.reg_wr = 1'b0;
      r.wval   = '0;
    end
    res_o = r;
  end

endmodule

`default_nettype wire

### design/mips_subset_execute_unit.sv
// Top level of the MIPS subset execute unit: stream ports, register file
// and data memory (both synchronous RAMs), pipeline control and forwarding.
// Depends on msx_pkg and msx_exec.
//
//   Channel   Dir  Beat contents
//   s_axis    in   one decoded instruction (command, registers, immediate, target)
//   m_axis    out  one result (status, next pc, register and memory activity)
//
// One instruction can enter every cycle while s_axis_tready is high. Stage one
// reads the register file RAM and executes; stage two holds the result while a
// load's data comes out of the data RAM. Results written back to registers are
// forwarded, so there is no interlock. After reset the data RAM is cleared one
// word a cycle, all MEM_WORDS (1024) words, with s_axis_tready low. A stalled
// m_axis freezes both stages.
`default_nettype none

module mips_subset_execute_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // command[3:0], src_reg_a[8:4], src_reg_b[13:9], dest_reg[18:14],
  // immediate[50:19], jump_target[82:51], zero fill[87:83]
  input  logic [msx_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // status[1:0], next_pc[33:2], reg_written[34], written_index[39:35],
  // written_value[71:40], mem_written[72], mem_index[82:73],
  // mem_value[114:83], zero fill[119:115]
  output logic [msx_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready
);
  import msx_pkg::*;

  localparam logic [MEM_AW-1:0] MemLast = MEM_AW'(MEM_WORDS - 1);

  // Input beat fields.
  logic [4:0]  s_ra;
  logic [4:0]  s_rb;
  logic        accept;
  logic        adv;
  logic        s1_move;

  // Register file RAM and its valid bits.
  logic [31:0] rf_mem [32];
  logic [31:0] rf_rd_a_q;
  logic [31:0] rf_rd_b_q;
  logic [31:0] rf_vld_q;
  logic        rf_we;
  logic [4:0]  rf_waddr;
  logic [31:0] rf_wdata;

  // Stage one: instruction and operand sources.
  logic        s1_valid_q;
  cmd_e        s1_cmd_q;
  logic [4:0]  s1_ra_q;
  logic [4:0]  s1_rb_q;
  logic [4:0]  s1_rd_q;
  logic [31:0] s1_imm_q;
  logic [31:0] s1_jt_q;
  logic        s1_rvld_a_q;
  logic        s1_rvld_b_q;
  logic        s1_byp_a_q;
  logic        s1_byp_b_q;
  logic [31:0] s1_bval_q;
  logic        fwd_a;
  logic        fwd_b;
  logic [31:0] op_a;
  logic [31:0] op_b;
  logic [31:0] pc_q;
  exec_t       ex;

  // Stage two: result awaiting the output handshake.
  logic        s2_valid_q;
  exec_t       s2_q;
  logic [31:0] s2_wdata;
  logic [31:0] s2_mval;

  // Data memory RAM and clearing pass.
  logic [31:0]       dmem [MEM_WORDS];
  logic [31:0]       dm_rdata_q;
  logic              dm_we;
  logic              dm_re;
  logic [MEM_AW-1:0] dm_waddr;
  logic [31:0]       dm_wdata;
  logic              clr_busy_q;
  logic [MEM_AW-1:0] clr_cnt_q;

  assign s_ra = s_axis_tdata[8:4];
  assign s_rb = s_axis_tdata[13:9];

  // Pipeline handshake: stage two drains on tready, stage one follows.
  assign adv           = !s2_valid_q || m_axis_tready;
  assign s1_move       = s1_valid_q && adv;
  assign s_axis_tready = !clr_busy_q && (!s1_valid_q || adv);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Register write-back happens when a result leaves stage two.
  assign rf_we    = s2_valid_q && adv && s2_q.reg_wr;
  assign rf_waddr = s2_q.widx;
  assign rf_wdata = s2_wdata;

  always_ff @(posedge clk_i) begin
    if (rf_we) rf_mem[rf_waddr] <= rf_wdata;
    if (accept) begin
      rf_rd_a_q <= rf_mem[s_ra];
      rf_rd_b_q <= rf_mem[s_rb];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
    end else if (rf_we) begin
      rf_vld_q[rf_waddr] <= 1'b1;
    end
  end

  // Stage one payload, with a bypass for a write landing on the read edge.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q    <= cmd_e'(s_axis_tdata[3:0]);
      s1_ra_q     <= s_ra;
      s1_rb_q     <= s_rb;
      s1_rd_q     <= s_axis_tdata[18:14];
      s1_imm_q    <= s_axis_tdata[50:19];
      s1_jt_q     <= s_axis_tdata[82:51];
      s1_rvld_a_q <= rf_vld_q[s_ra];
      s1_rvld_b_q <= rf_vld_q[s_rb];
      s1_byp_a_q  <= rf_we && (rf_waddr == s_ra);
      s1_byp_b_q  <= rf_we && (rf_waddr == s_rb);
      s1_bval_q   <= rf_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Operand selection: forward from stage two, then bypass, then the RAM.
  assign fwd_a = s2_valid_q && s2_q.reg_wr && (s2_q.widx == s1_ra_q);
  assign fwd_b = s2_valid_q && s2_q.reg_wr && (s2_q.widx == s1_rb_q);

  always_comb begin
    if (fwd_a)            op_a = s2_wdata;
    else if (s1_byp_a_q)  op_a = s1_bval_q;
    else if (s1_rvld_a_q) op_a = rf_rd_a_q;
    else                  op_a = '0;
    if (fwd_b)            op_b = s2_wdata;
    else if (s1_byp_b_q)  op_b = s1_bval_q;
    else if (s1_rvld_b_q) op_b = rf_rd_b_q;
    else                  op_b = '0;
  end

  msx_exec u_exec (
    .cmd_i (s1_cmd_q),
    .a_i   (op_a),
    .b_i   (op_b),
    .rt_i  (s1_rb_q),
    .rd_i  (s1_rd_q),
    .imm_i (s1_imm_q),
    .jt_i  (s1_jt_q),
    .pc_i  (pc_q),
    .res_o (ex)
  );

  // Program counter commits as the instruction leaves stage one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
    end else if (s1_move) begin
      pc_q <= ex.npc;
    end
  end

  // Data memory: clearing pass, store commit and load read share the RAM.
  assign dm_we    = clr_busy_q || (s1_move && ex.mem_wr);
  assign dm_waddr = clr_busy_q ? clr_cnt_q : ex.maddr[MEM_AW-1:0];
  assign dm_wdata = clr_busy_q ? 32'd0 : ex.mval;
  assign dm_re    = s1_move && ex.ld;

  always_ff @(posedge clk_i) begin
    if (dm_we) dmem[dm_waddr] <= dm_wdata;
    if (dm_re) dm_rdata_q <= dmem[ex.maddr[MEM_AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == MemLast) clr_busy_q <= 1'b0;
    end
  end

  // Stage two register.
  always_ff @(posedge clk_i) begin
    if (s1_move) s2_q <= ex;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  // Load data joins the result here.
  assign s2_wdata = (s2_q.ld && s2_q.reg_wr) ? dm_rdata_q : s2_q.wval;
  assign s2_mval  = s2_q.ld ? dm_rdata_q : s2_q.mval;

  assign m_axis_tvalid = s2_valid_q;
  assign m_axis_tdata  = {5'd0,
                          s2_mval,
                          s2_q.maddr[9:0],
                          s2_q.mem_wr,
                          s2_wdata,
                          s2_q.widx,
                          s2_q.reg_wr,
                          s2_q.npc,
                          s2_q.status};

endmodule

`default_nettype wire

### bench/tb_top.sv
// Self-checking bench for mips_subset_execute_unit: a directed set of instructions,
// an output hold-off and a long random program are checked against a cycle-free model.
// Depends on msx_pkg and the design files of the execute unit.

module tb_top;
  import msx_pkg::*;

  localparam int unsigned INSTR_W   = 83;
  localparam int unsigned OUTCOME_W = 115;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam logic [3:0] CMD_NOP_HI = 4'd15;
  localparam logic [3:0] CMD_NOP_LO = 4'd12;

  // One instruction beat, first field in the lowest bits.
  typedef struct packed {
    logic [31:0] jump_target;
    logic [31:0] immediate;
    logic [4:0]  dest_reg;
    logic [4:0]  src_reg_b;
    logic [4:0]  src_reg_a;
    logic [3:0]  command;
  } instr_t;

  // One result beat, first field in the lowest bits.
  typedef struct packed {
    logic [31:0] mem_value;
    logic [9:0]  mem_index;
    logic        mem_written;
    logic [31:0] written_value;
    logic [4:0]  written_index;
    logic        reg_written;
    logic [31:0] next_pc;
    logic [1:0]  status;
  } outcome_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;

  // Architectural state of the model, updated when a beat is accepted.
  logic [31:0] gpr_model [32];
  logic [31:0] dmem_model [MEM_WORDS];
  logic [31:0] pc_model;

  outcome_t pending_q [$];
  outcome_t want_res;
  outcome_t got_res;
  int       err_count = 0;
  bit       no_idle = 1'b0;
  bit       hold_req = 1'b0;

  mips_subset_execute_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  // Clock with a period of 10.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint sext(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic void reset_model();
    for (int i = 0; i < 32; i++) gpr_model[i] = '0;
    for (int i = 0; i < MEM_WORDS; i++) dmem_model[i] = '0;
    pc_model = '0;
  endfunction

  // Executes one instruction on the model state and returns its result.
  function automatic outcome_t execute_instr(instr_t ins);
    longint      a, b, imm, jt, wval, maddr, tgt, pc_lim;
    logic [31:0] seq, npc, mval;
    logic [4:0]  widx;
    logic        wr, mw, macc;
    status_e     st;
    outcome_t    res;
    a      = sext(gpr_model[ins.src_reg_a]);
    b      = sext(gpr_model[ins.src_reg_b]);
    imm    = sext(ins.immediate);
    jt     = sext(ins.jump_target);
    pc_lim = 4 * longint'(MEM_WORDS);
    seq    = pc_model + 32'd4;
    npc    = seq;
    st     = ST_OK;
    wr     = 1'b0;
    widx   = '0;
    wval   = 0;
    mw     = 1'b0;
    macc   = 1'b0;
    maddr  = 0;
    mval   = '0;
    case (ins.command)
      CMD_ADD, CMD_SUB, CMD_ADDI: begin
        if (ins.command == CMD_ADD) wval = a + b;
        else if (ins.command == CMD_SUB) wval = a - b;
        else wval = a + imm;
        widx = (ins.command == CMD_ADDI) ? ins.src_reg_b : ins.dest_reg;
        wr   = 1'b1;
        if (wval != sext(wval[31:0])) st = ST_OVF;
      end
      CMD_AND: begin
        wval = sext(a[31:0] & b[31:0]);
        widx = ins.dest_reg;
        wr   = 1'b1;
      end
      CMD_OR: begin
        wval = sext(a[31:0] | b[31:0]);
        widx = ins.dest_reg;
        wr   = 1'b1;
      end
      CMD_SLT: begin
        wval = (a < b) ? 1 : 0;
        widx = ins.dest_reg;
        wr   = 1'b1;
      end
      CMD_JR: begin
        if (a < 0 || a >= pc_lim) st = ST_ADDR;
        else npc = a[31:0];
      end
      CMD_LW, CMD_SW: begin
        maddr = a + imm;
        if (maddr < 0 || maddr >= longint'(MEM_WORDS)) begin
          st = ST_ADDR;
        end else begin
          macc = 1'b1;
          if (ins.command == CMD_LW) begin
            mval = dmem_model[maddr[MEM_AW-1:0]];
            wval = sext(mval);
            widx = ins.src_reg_b;
            wr   = 1'b1;
          end else begin
            mval = b[31:0];
            mw   = 1'b1;
          end
        end
      end
      CMD_BEQ: begin
        // The target is only checked when the branch is taken.
        if (a == b) begin
          tgt = pc_model;
          tgt = tgt + imm * 4;
          if (tgt < 0 || tgt >= pc_lim) st = ST_ADDR;
          else npc = tgt[31:0];
        end
      end
      CMD_J, CMD_JAL: begin
        tgt = jt * 4;
        if (tgt < 0 || tgt >= pc_lim) begin
          st = ST_ADDR;
        end else begin
          npc = tgt[31:0];
          if (ins.command == CMD_JAL) begin
            wval = sext(seq);
            widx = 5'd31;
            wr   = 1'b1;
          end
        end
      end
      default: ;
    endcase

    res = '0;
    if (st != ST_OK) begin
      // Errors leave all state alone and report the current pc.
      res.status  = st;
      res.next_pc = pc_model;
      return res;
    end
    if (wr && widx != 0) begin
      gpr_model[widx] = wval[31:0];
    end else begin
      wr   = 1'b0;
      widx = '0;
      wval = 0;
    end
    if (mw) dmem_model[maddr[MEM_AW-1:0]] = mval;
    pc_model = npc;

    res.status        = ST_OK;
    res.next_pc       = npc;
    res.reg_written   = wr;
    res.written_index = widx;
    res.written_value = wval[31:0];
    res.mem_written   = mw;
    res.mem_index     = macc ? maddr[9:0] : 10'd0;
    res.mem_value     = macc ? mval : 32'd0;
    return res;
  endfunction

  function automatic instr_t mk(logic [3:0] cmd, int ra, int rb, int rd, int imm, int jt);
    instr_t ins;
    ins.command     = cmd;
    ins.src_reg_a   = ra[4:0];
    ins.src_reg_b   = rb[4:0];
    ins.dest_reg    = rd[4:0];
    ins.immediate   = imm;
    ins.jump_target = jt;
    return ins;
  endfunction

  // Mostly short gaps, a few long ones, none while a quiet stretch runs.
  function automatic int gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offers one instruction beat and waits until it is taken.
  task automatic send_instr(instr_t ins);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata  <= {{(S_TDATA_W - INSTR_W){1'b0}}, ins};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_q.push_back(execute_instr(ins));
  endtask

  // Builds a random instruction; most are shaped to succeed, the rest are noise.
  function automatic instr_t rand_instr();
    instr_t      ins;
    logic [95:0] raw;
    int unsigned pick;
    longint      want;
    raw = {$urandom, $urandom, $urandom};
    ins = raw[INSTR_W-1:0];
    if ($urandom_range(0, 99) < 20) return ins;

    // Keep most register indices in a small window so results are reused.
    if ($urandom_range(0, 4) != 0) ins.src_reg_a = 5'($urandom_range(0, 7));
    if ($urandom_range(0, 4) != 0) ins.src_reg_b = 5'($urandom_range(0, 7));
    if ($urandom_range(0, 4) != 0) ins.dest_reg  = 5'($urandom_range(0, 7));
    pick = $urandom_range(0, 99);
    if (pick < 10)      ins.command = CMD_ADD;
    else if (pick < 16) ins.command = CMD_SUB;
    else if (pick < 22) ins.command = CMD_AND;
    else if (pick < 28) ins.command = CMD_OR;
    else if (pick < 34) ins.command = CMD_SLT;
    else if (pick < 40) ins.command = CMD_JR;
    else if (pick < 55) ins.command = CMD_ADDI;
    else if (pick < 68) ins.command = CMD_LW;
    else if (pick < 81) ins.command = CMD_SW;
    else if (pick < 89) ins.command = CMD_BEQ;
    else if (pick < 95) ins.command = CMD_J;
    else                ins.command = CMD_JAL;

    case (ins.command)
      CMD_ADDI: begin
        pick = $urandom_range(0, 9);
        if (pick < 5) ins.immediate = $urandom_range(0, 4095);
        else if (pick < 8) ins.immediate = $urandom_range(0, 32) - 16;
      end
      CMD_LW, CMD_SW: begin
        // Aim the word index at a small window, sometimes just past an end.
        pick = $urandom_range(0, 9);
        if (pick < 7) want = $urandom_range(0, 31);
        else if (pick < 9) want = $urandom_range(0, MEM_WORDS - 1);
        else want = longint'($urandom_range(0, 5)) - 3 + ($urandom_range(0, 1) ? MEM_WORDS : 0);
        want = want - sext(gpr_model[ins.src_reg_a]);
        ins.immediate = want[31:0];
      end
      CMD_BEQ: begin
        if ($urandom_range(0, 1)) ins.src_reg_b = ins.src_reg_a;
        if ($urandom_range(0, 5) != 0) begin
          want = longint'($urandom_range(0, MEM_WORDS - 1)) * 4 - longint'(pc_model);
          want = want / 4;
          ins.immediate = want[31:0];
        end
      end
      CMD_J, CMD_JAL: begin
        pick = $urandom_range(0, 19);
        if (pick < 17) ins.jump_target = $urandom_range(0, MEM_WORDS - 1);
        else if (pick < 19) ins.jump_target = $urandom_range(0, 1) ? -1 : MEM_WORDS;
      end
      default: ;
    endcase
    return ins;
  endfunction

  // Overflow on add and sub upward and on addi downward, next to plain sums.
  task automatic test_arith_overflow();
    send_instr(mk(CMD_ADDI, 0, 1, 0, 32'h7fff_ffff, 0));
    send_instr(mk(CMD_ADDI, 0, 2, 0, 1, 0));
    send_instr(mk(CMD_ADD, 1, 2, 3, 0, 0));
    send_instr(mk(CMD_ADDI, 0, 4, 0, 32'h8000_0000, 0));
    send_instr(mk(CMD_SUB, 0, 4, 5, 0, 0));
    send_instr(mk(CMD_ADDI, 4, 10, 0, -1, 0));
  endtask

  // Bitwise operations, signed compare and a write to register zero.
  task automatic test_logic_compare();
    send_instr(mk(CMD_AND, 1, 4, 6, 0, 0));
    send_instr(mk(CMD_OR, 1, 4, 7, 0, 0));
    send_instr(mk(CMD_SLT, 4, 1, 8, 0, 0));
    send_instr(mk(CMD_OR, 1, 2, 0, 0, 0));
  endtask

  // Loads and stores at both ends of the memory and just outside it.
  task automatic test_memory_access();
    send_instr(mk(CMD_SW, 0, 1, 0, MEM_WORDS - 1, 0));
    send_instr(mk(CMD_LW, 0, 9, 0, MEM_WORDS - 1, 0));
    send_instr(mk(CMD_SW, 2, 4, 0, -1, 0));
    send_instr(mk(CMD_LW, 0, 0, 0, 0, 0));
    send_instr(mk(CMD_LW, 0, 9, 0, MEM_WORDS, 0));
    send_instr(mk(CMD_SW, 0, 1, 0, -1, 0));
  endtask

  // Jumps, links, register jumps, branches taken and not, unused codes.
  task automatic test_control_flow();
    send_instr(mk(CMD_J, 0, 0, 0, 0, MEM_WORDS - 1));
    send_instr(mk(CMD_J, 0, 0, 0, 0, MEM_WORDS));
    send_instr(mk(CMD_JAL, 0, 0, 0, 0, 5));
    send_instr(mk(CMD_JR, 31, 0, 0, 0, 0));
    send_instr(mk(CMD_JR, 4, 0, 0, 0, 0));
    send_instr(mk(CMD_BEQ, 0, 0, 0, 0, 0));
    send_instr(mk(CMD_BEQ, 1, 2, 0, 32'h7fff_ffff, 0));
    send_instr(mk(CMD_BEQ, 0, 0, 0, -1000000, 0));
    send_instr(mk(CMD_NOP_HI, 31, 31, 31, -1, -1));
    send_instr(mk(CMD_NOP_LO, 1, 2, 3, 32'h8000_0000, 32'h8000_0000));
  endtask

  // The receiver holds off while beats keep coming, so the pipeline fills.
  task automatic test_output_backpressure();
    no_idle  = 1'b1;
    hold_req = 1'b1;
    repeat (40) send_instr(rand_instr());
    no_idle = 1'b0;
  endtask

  // A long random program in stretches with and without idle cycles.
  task automatic test_random_program();
    for (int chunk = 0; chunk < 7; chunk++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      repeat (50) send_instr(rand_instr());
    end
    no_idle = 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off when requested.
  initial begin : rx_ready
    int stall;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        stall = gap_len();
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      err_count++;
    end
  endtask

  // Each result beat is compared with the oldest expected result.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_res = m_axis_tdata[OUTCOME_W-1:0];
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %h", $time, m_axis_tdata);
        err_count++;
      end else begin
        want_res = pending_q.pop_front();
        check_field("status", 32'(want_res.status), 32'(got_res.status));
        check_field("next_pc", want_res.next_pc, got_res.next_pc);
        check_field("reg_written", 32'(want_res.reg_written), 32'(got_res.reg_written));
        check_field("written_index", 32'(want_res.written_index), 32'(got_res.written_index));
        check_field("written_value", want_res.written_value, got_res.written_value);
        check_field("mem_written", 32'(want_res.mem_written), 32'(got_res.mem_written));
        check_field("mem_index", 32'(want_res.mem_index), 32'(got_res.mem_index));
        check_field("mem_value", want_res.mem_value, got_res.mem_value);
      end
    end
  end

  // Watchdog for a hung run.
  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

  // Reset, the test sequence, then drain and report.
  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    reset_model();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_arith_overflow();
    test_logic_compare();
    test_memory_access();
    test_control_flow();
    test_output_backpressure();
    test_random_program();
    s_axis_tvalid <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
